// ===== sv/tbpc_pkg.sv =====
`timescale 1ns / 1ps

package tbpc_pkg;

    // Field and register widths
    localparam int unsigned STEP_W  = 8;
    localparam int unsigned LONG_W  = 12;
    localparam int unsigned EVENT_W = 3;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 16;

    // Register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_STEP  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_STEP    = 8'd3;

    // Register reset values
    localparam logic [STEP_W-1:0] WINDOW_TICKS_RST = 8'd20;
    localparam logic [STEP_W-1:0] SAMPLE_STEP_RST  = 8'd4;
    localparam logic [LONG_W-1:0] LONG_TICKS_RST   = 12'd600;
    localparam logic [STEP_W-1:0] HOLD_STEP_RST    = 8'd20;

    // Event codes
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE      = 3'd0,
        EV_SEL_SHORT = 3'd1,
        EV_SEL_LONG  = 3'd2,
        EV_OK_SHORT  = 3'd3,
        EV_OK_LONG   = 3'd4
    } event_t;

    // Current register set handed to the classifier
    typedef struct packed {
        logic [STEP_W-1:0] window_ticks;
        logic [STEP_W-1:0] sample_step;
        logic [LONG_W-1:0] long_ticks;
        logic [STEP_W-1:0] hold_step;
    } cfg_t;

endpackage

// ===== sv/tbpc_if.sv =====
`timescale 1ns / 1ps

// Tick channel: raw active-low pin levels
interface tbpc_item_if;
    logic valid;
    logic ready;
    logic select_level;
    logic ok_level;

    modport source (output valid, output select_level, output ok_level, input ready);
    modport sink   (input valid, input select_level, input ok_level, output ready);
endinterface

// Result channel: classified event
interface tbpc_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;

    modport source (output valid, output event_res, input ready);
    modport sink   (input valid, input event_res, output ready);
endinterface

// Config write channel
interface tbpc_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/tbpc_cfg.sv =====
`timescale 1ns / 1ps

module tbpc_cfg
    import tbpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tbpc_cfg_if.sink   cfg,
    output cfg_t       regs
);

    logic [STEP_W-1:0] window_ticks_reg;
    logic [STEP_W-1:0] sample_step_reg;
    logic [LONG_W-1:0] long_ticks_reg;
    logic [STEP_W-1:0] hold_step_reg;
    logic              wr_en;

    // Writes are always taken
    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ticks_reg <= WINDOW_TICKS_RST;
            sample_step_reg  <= SAMPLE_STEP_RST;
            long_ticks_reg   <= LONG_TICKS_RST;
            hold_step_reg    <= HOLD_STEP_RST;
        end
        else if (wr_en)
        begin
            unique case (cfg.index)
                REG_WINDOW_TICKS: window_ticks_reg <= cfg.data[STEP_W-1:0];
                REG_SAMPLE_STEP:  sample_step_reg  <= cfg.data[STEP_W-1:0];
                REG_LONG_TICKS:   long_ticks_reg   <= cfg.data[LONG_W-1:0];
                REG_HOLD_STEP:    hold_step_reg    <= cfg.data[STEP_W-1:0];
                default:          ;
            endcase
        end
    end

    assign regs.window_ticks = window_ticks_reg;
    assign regs.sample_step  = sample_step_reg;
    assign regs.long_ticks   = long_ticks_reg;
    assign regs.hold_step    = hold_step_reg;

endmodule

// ===== sv/tbpc_core.sv =====
`timescale 1ns / 1ps

module tbpc_core
    import tbpc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   regs,
    input  logic   accept,
    input  logic   select_level,
    input  logic   ok_level,
    output logic   res_valid,
    output event_t res_code
);

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_WINDOW = 2'd1,
        PH_HOLD   = 2'd2,
        PH_DRAIN  = 2'd3
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [STEP_W-1:0] step_count_reg, step_count_next;
    logic [STEP_W-1:0] window_count_reg, window_count_next;
    logic [LONG_W-1:0] held_count_reg, held_count_next;
    logic              select_seen_reg, select_seen_next;
    logic              ok_seen_reg, ok_seen_next;
    logic              chose_select_reg, chose_select_next;
    logic              long_seen_reg, long_seen_next;

    logic              sel_low, ok_low, pin_low;
    logic [STEP_W-1:0] win_per, smp_per, hld_per;
    logic [STEP_W:0]   step_inc;
    logic [STEP_W:0]   win_sum;
    logic [LONG_W:0]   held_sum;
    logic              do_hold, do_drain;

    assign sel_low = ~select_level;
    assign ok_low  = ~ok_level;

    // A zero period acts as one
    assign win_per = (regs.window_ticks == '0) ? STEP_W'(1) : regs.window_ticks;
    assign smp_per = (regs.sample_step == '0)  ? STEP_W'(1) : regs.sample_step;
    assign hld_per = (regs.hold_step == '0)    ? STEP_W'(1) : regs.hold_step;
    assign step_inc = {1'b0, step_count_reg} + (STEP_W+1)'(1);

    // Next-state logic for one tick
    always_comb
    begin
        phase_next        = phase_reg;
        step_count_next   = step_count_reg;
        window_count_next = window_count_reg;
        held_count_next   = held_count_reg;
        select_seen_next  = select_seen_reg;
        ok_seen_next      = ok_seen_reg;
        chose_select_next = chose_select_reg;
        long_seen_next    = long_seen_reg;
        res_valid         = 1'b0;
        res_code          = EV_NONE;
        do_hold           = 1'b0;
        do_drain          = 1'b0;
        win_sum           = '0;
        held_sum          = '0;

        if (accept)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (sel_low || ok_low)
                    begin
                        phase_next        = PH_WINDOW;
                        step_count_next   = '0;
                        window_count_next = '0;
                        held_count_next   = '0;
                        select_seen_next  = 1'b0;
                        ok_seen_next      = 1'b0;
                        chose_select_next = 1'b0;
                        long_seen_next    = 1'b0;
                    end
                end
                PH_WINDOW:
                begin
                    if (step_inc >= {1'b0, smp_per})
                    begin
                        step_count_next  = '0;
                        select_seen_next = select_seen_reg | sel_low;
                        ok_seen_next     = ok_seen_reg | ok_low;
                        win_sum = {1'b0, window_count_reg} + {1'b0, smp_per};
                        window_count_next = win_sum[STEP_W] ? '1 : win_sum[STEP_W-1:0];
                        if (window_count_next >= win_per)
                        begin
                            if (!select_seen_next && !ok_seen_next)
                            begin
                                res_valid  = 1'b1;
                                res_code   = EV_NONE;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                chose_select_next = select_seen_next;
                                held_count_next   = LONG_W'(win_per);
                                do_hold           = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        step_count_next = step_inc[STEP_W-1:0];
                    end
                end
                PH_HOLD:
                begin
                    if (step_inc >= {1'b0, hld_per})
                    begin
                        step_count_next = '0;
                        held_sum = {1'b0, held_count_reg} + (LONG_W+1)'(hld_per);
                        held_count_next = held_sum[LONG_W] ? '1 : held_sum[LONG_W-1:0];
                        do_hold = 1'b1;
                    end
                    else
                    begin
                        step_count_next = step_inc[STEP_W-1:0];
                    end
                end
                PH_DRAIN:
                begin
                    if (step_inc >= {1'b0, hld_per})
                    begin
                        step_count_next = '0;
                        do_drain        = 1'b1;
                    end
                    else
                    begin
                        step_count_next = step_inc[STEP_W-1:0];
                    end
                end
                default: ;
            endcase
        end

        pin_low = chose_select_next ? sel_low : ok_low;

        // Hold check: keep holding while pressed and short of the threshold
        if (do_hold)
        begin
            if (pin_low && (held_count_next < regs.long_ticks))
            begin
                phase_next      = PH_HOLD;
                step_count_next = '0;
            end
            else
            begin
                long_seen_next = (held_count_next >= regs.long_ticks);
                do_drain       = 1'b1;
            end
        end

        // Drain check: report on release
        if (do_drain)
        begin
            if (pin_low)
            begin
                phase_next      = PH_DRAIN;
                step_count_next = '0;
            end
            else
            begin
                res_valid  = 1'b1;
                phase_next = PH_IDLE;
                if (chose_select_next)
                begin
                    res_code = long_seen_next ? EV_SEL_LONG : EV_SEL_SHORT;
                end
                else
                begin
                    res_code = long_seen_next ? EV_OK_LONG : EV_OK_SHORT;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            step_count_reg   <= '0;
            window_count_reg <= '0;
            held_count_reg   <= '0;
            select_seen_reg  <= 1'b0;
            ok_seen_reg      <= 1'b0;
            chose_select_reg <= 1'b0;
            long_seen_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            step_count_reg   <= step_count_next;
            window_count_reg <= window_count_next;
            held_count_reg   <= held_count_next;
            select_seen_reg  <= select_seen_next;
            ok_seen_reg      <= ok_seen_next;
            chose_select_reg <= chose_select_next;
            long_seen_reg    <= long_seen_next;
        end
    end

endmodule

// ===== sv/tbpc_out.sv =====
`timescale 1ns / 1ps

module tbpc_out
    import tbpc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  event_t        push_code,
    output logic          can_accept,
    tbpc_result_if.source result
);

    logic   main_vld_reg, skid_vld_reg;
    event_t main_code_reg, skid_code_reg;
    logic   pop;

    assign pop        = main_vld_reg & result.ready;
    assign can_accept = ~skid_vld_reg;

    assign result.valid     = main_vld_reg;
    assign result.event_res = main_code_reg;

    // Output register with one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_vld_reg)
            begin
                skid_vld_reg <= 1'b0;
            end
            else
            begin
                main_vld_reg <= push;
            end
        end
        else if (push)
        begin
            if (!main_vld_reg)
            begin
                main_vld_reg <= 1'b1;
            end
            else
            begin
                skid_vld_reg <= 1'b1;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            main_code_reg <= skid_vld_reg ? skid_code_reg : push_code;
        end
        else if (push)
        begin
            if (!main_vld_reg)
            begin
                main_code_reg <= push_code;
            end
            else
            begin
                skid_code_reg <= push_code;
            end
        end
    end

endmodule

// ===== sv/two_button_press_classifier_top.sv =====
`timescale 1ns / 1ps
// A tick that ends a press pushes its event into the registered result stage.
// Throughput: one tick per cycle while the skid entry is empty.
// The result stage holds two events, so ticks keep flowing while one waits.
// Reset (rst_n, async, active low): idle, counters cleared, no pending event,
// registers back to window 20, sample step 4, long 600, hold step 20.

module two_button_press_classifier_top
    import tbpc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tbpc_item_if.sink     item,
    tbpc_result_if.source result,
    tbpc_cfg_if.sink      cfg
);

    cfg_t   regs;
    logic   accept;
    logic   can_accept;
    logic   res_valid;
    event_t res_code;

    assign item.ready = can_accept;
    assign accept     = item.valid & can_accept;

    tbpc_cfg u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    tbpc_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .regs         (regs),
        .accept       (accept),
        .select_level (item.select_level),
        .ok_level     (item.ok_level),
        .res_valid    (res_valid),
        .res_code     (res_code)
    );

    tbpc_out u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept & res_valid),
        .push_code  (res_code),
        .can_accept (can_accept),
        .result     (result)
    );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import tbpc_pkg::*;

    typedef enum logic [1:0] {PH_IDLE, PH_WINDOW, PH_HOLD, PH_DRAIN} phase_t;

    localparam int STALL_LONG = 300;
    localparam int FAIL_SHOW  = 10;

    logic clk = 1'b0;
    logic rst_n;

    tbpc_item_if   item_ch();
    tbpc_result_if result_ch();
    tbpc_cfg_if    cfg_ch();

    two_button_press_classifier_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Clock, 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    // Predicted register copies
    bit [STEP_W-1:0] p_window;
    bit [STEP_W-1:0] p_sample;
    bit [LONG_W-1:0] p_long;
    bit [STEP_W-1:0] p_hold;

    // Predicted classifier state
    phase_t          ph;
    bit [7:0]        step_cnt;
    bit [7:0]        win_cnt;
    bit [11:0]       held_cnt;
    bit              sel_seen;
    bit              ok_seen;
    bit              pick_sel;
    bit              was_long;

    event_t expected_events[$];

    int ticks_sent;
    int ticks_taken;
    int reg_writes;
    int results_seen;
    int bounce_cnt;
    int short_cnt;
    int long_cnt;
    int failures;
    int src_idle_pct;
    int snk_idle_pct;
    int stall_cycles;

    function automatic int unsigned floor_one(input int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    function void note_failure(input string msg);
        failures++;
        if (failures <= FAIL_SHOW)
            $display("%s", msg);
    endfunction

    function void reset_predictor();
        p_window = WINDOW_TICKS_RST;
        p_sample = SAMPLE_STEP_RST;
        p_long   = LONG_TICKS_RST;
        p_hold   = HOLD_STEP_RST;
        ph       = PH_IDLE;
        step_cnt = '0;
        win_cnt  = '0;
        held_cnt = '0;
        sel_seen = 1'b0;
        ok_seen  = 1'b0;
        pick_sel = 1'b0;
        was_long = 1'b0;
    endfunction

    function void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_WINDOW_TICKS: p_window = val[STEP_W-1:0];
            REG_SAMPLE_STEP:  p_sample = val[STEP_W-1:0];
            REG_LONG_TICKS:   p_long   = val[LONG_W-1:0];
            REG_HOLD_STEP:    p_hold   = val[STEP_W-1:0];
            default: ;
        endcase
    endfunction

    // One tick toward a sample or check period; true when the period is done
    function bit period_done(input int unsigned period);
        if (step_cnt + 1 >= floor_one(period))
        begin
            step_cnt = '0;
            return 1'b1;
        end
        step_cnt = step_cnt + 8'd1;
        return 1'b0;
    endfunction

    // Predict the effect of one accepted tick
    task automatic classify_tick(input bit sel_lvl, input bit ok_lvl,
                                 output bit fired, output event_t ev);
        bit          sel_low;
        bit          ok_low;
        bit          pin_low;
        bit          hold_due;
        bit          drain_due;
        int unsigned sum;

        sel_low   = !sel_lvl;
        ok_low    = !ok_lvl;
        hold_due  = 1'b0;
        drain_due = 1'b0;
        fired     = 1'b0;
        ev        = EV_NONE;

        case (ph)
            PH_IDLE:
            begin
                if (sel_low || ok_low)
                begin
                    ph       = PH_WINDOW;
                    step_cnt = '0;
                    win_cnt  = '0;
                    held_cnt = '0;
                    sel_seen = 1'b0;
                    ok_seen  = 1'b0;
                    pick_sel = 1'b0;
                    was_long = 1'b0;
                end
            end
            PH_WINDOW:
            begin
                if (period_done(p_sample))
                begin
                    sel_seen = sel_seen || sel_low;
                    ok_seen  = ok_seen || ok_low;
                    sum      = win_cnt + floor_one(p_sample);
                    win_cnt  = (sum > 255) ? 8'd255 : sum[7:0];
                    if (win_cnt >= floor_one(p_window))
                    begin
                        if (!sel_seen && !ok_seen)
                        begin
                            // nothing seen in the window: bounce
                            fired = 1'b1;
                            ev    = EV_NONE;
                            ph    = PH_IDLE;
                        end
                        else
                        begin
                            // Select wins when both were seen
                            pick_sel = sel_seen;
                            held_cnt = 12'(floor_one(p_window));
                            hold_due = 1'b1;
                        end
                    end
                end
            end
            PH_HOLD:
            begin
                if (period_done(p_hold))
                begin
                    sum      = held_cnt + floor_one(p_hold);
                    held_cnt = (sum > 4095) ? 12'd4095 : sum[11:0];
                    hold_due = 1'b1;
                end
            end
            default:
            begin
                if (period_done(p_hold))
                    drain_due = 1'b1;
            end
        endcase

        pin_low = pick_sel ? sel_low : ok_low;

        // hold check; falls through to the drain check once the hold is over
        if (hold_due)
        begin
            if (pin_low && held_cnt < p_long)
            begin
                ph       = PH_HOLD;
                step_cnt = '0;
            end
            else
            begin
                was_long  = held_cnt >= p_long;
                drain_due = 1'b1;
            end
        end

        if (drain_due)
        begin
            if (pin_low)
            begin
                ph       = PH_DRAIN;
                step_cnt = '0;
            end
            else
            begin
                fired = 1'b1;
                if (pick_sel)
                    ev = was_long ? EV_SEL_LONG : EV_SEL_SHORT;
                else
                    ev = was_long ? EV_OK_LONG : EV_OK_SHORT;
                ph = PH_IDLE;
            end
        end
    endtask

    // Beat monitor: checks results, predicts ticks, tracks register writes
    always @(posedge clk)
    begin : monitor
        bit     fired;
        event_t ev;
        event_t want;

        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                results_seen++;
                if (expected_events.size() == 0)
                    note_failure($sformatf("unexpected result %0d after tick %0d",
                                           result_ch.event_res, ticks_taken));
                else
                begin
                    want = expected_events.pop_front();
                    if (result_ch.event_res !== want)
                        note_failure($sformatf("mismatch after tick %0d: expected %s (%0d) actual %0d",
                                               ticks_taken, want.name(), want,
                                               result_ch.event_res));
                    case (want) inside
                        EV_NONE:                   bounce_cnt++;
                        EV_SEL_SHORT, EV_OK_SHORT: short_cnt++;
                        default:                   long_cnt++;
                    endcase
                end
            end
            if (item_ch.valid && item_ch.ready)
            begin
                ticks_taken++;
                classify_tick(item_ch.select_level, item_ch.ok_level, fired, ev);
                if (fired)
                    expected_events.push_back(ev);
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                reg_writes++;
                apply_reg(cfg_ch.index, cfg_ch.data);
            end
        end
    end

    // Result sink: random stalls, or a long hold-off when requested
    always @(negedge clk)
    begin
        if (stall_cycles > 0)
        begin
            result_ch.ready <= 1'b0;
            stall_cycles = stall_cycles - 1;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Offer one tick and wait for its beat; valid stays high afterwards
    task automatic send_tick(input bit sel_lvl, input bit ok_lvl);
        while ($urandom_range(99) < src_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.select_level <= sel_lvl;
        item_ch.ok_level     <= ok_lvl;
        ticks_sent++;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic hold_levels(input bit sel_lvl, input bit ok_lvl, input int n);
        repeat (n) send_tick(sel_lvl, ok_lvl);
    endtask

    // Stop ticks and wait until every expected result is in
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (expected_events.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_config(input int unsigned w, input int unsigned s,
                              input int unsigned l, input int unsigned h);
        write_reg(REG_WINDOW_TICKS, w);
        write_reg(REG_SAMPLE_STEP, s);
        write_reg(REG_LONG_TICKS, l);
        write_reg(REG_HOLD_STEP, h);
        cfg_ch.valid <= 1'b0;
    endtask

    // Reset values: bounce, then a short Select press
    task automatic test_defaults();
        hold_levels(1'b1, 1'b0, 1);
        hold_levels(1'b1, 1'b1, 24);
        hold_levels(1'b0, 1'b1, 60);
        hold_levels(1'b1, 1'b1, 30);
        settle();
    endtask

    // Every event kind with a fast setting
    task automatic test_press_kinds();
        set_config(2, 1, 6, 1);
        hold_levels(1'b0, 1'b1, 3);
        hold_levels(1'b1, 1'b1, 4);
        hold_levels(1'b0, 1'b1, 10);
        hold_levels(1'b1, 1'b1, 3);
        hold_levels(1'b1, 1'b0, 3);
        hold_levels(1'b1, 1'b1, 4);
        hold_levels(1'b1, 1'b0, 10);
        hold_levels(1'b1, 1'b1, 3);
        // both pins down: Select wins
        hold_levels(1'b0, 1'b0, 3);
        hold_levels(1'b1, 1'b1, 3);
        // bounce, then low again on the next tick so it re-arms
        hold_levels(1'b0, 1'b1, 1);
        hold_levels(1'b1, 1'b1, 2);
        hold_levels(1'b0, 1'b1, 4);
        hold_levels(1'b1, 1'b1, 3);
        settle();
    endtask

    // Zero in every register: steps act as 1, every press is long
    task automatic test_zero_regs();
        set_config(0, 0, 0, 0);
        hold_levels(1'b1, 1'b0, 2);
        hold_levels(1'b1, 1'b1, 2);
        hold_levels(1'b0, 1'b1, 1);
        hold_levels(1'b1, 1'b1, 2);
        hold_levels(1'b0, 1'b0, 3);
        hold_levels(1'b1, 1'b1, 2);
        settle();
    endtask

    // Largest values: window count saturates, then one first sample fills the window
    task automatic test_extremes();
        set_config(255, 200, 4095, 10);
        hold_levels(1'b0, 1'b1, 420);
        hold_levels(1'b1, 1'b1, 30);
        settle();
        set_config(1, 255, 1, 1);
        hold_levels(1'b1, 1'b0, 270);
        hold_levels(1'b1, 1'b1, 10);
        settle();
    endtask

    // Result sink held off while bounces keep coming, so the input stalls
    task automatic test_backpressure();
        int saved_src;

        saved_src    = src_idle_pct;
        src_idle_pct = 0;
        set_config(1, 1, 4095, 1);
        stall_cycles = STALL_LONG;
        repeat (40)
        begin
            send_tick(1'b0, 1'b1);
            send_tick(1'b1, 1'b1);
        end
        settle();
        src_idle_pct = saved_src;
    endtask

    // Mostly small settings so that presses finish quickly
    task automatic random_config();
        int unsigned w;
        int unsigned s;
        int unsigned l;
        int unsigned h;

        w = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 10);
        s = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 4);
        h = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 6);
        case ($urandom_range(9))
            0:       l = 0;
            1:       l = $urandom_range(1000, 4095);
            default: l = $urandom_range(1, 50);
        endcase
        set_config(w, s, l, h);
    endtask

    // One press with chatter, or noise, or a lone glitch
    task automatic press_sequence();
        int          kind;
        int unsigned limit;
        bit          sel_lvl;
        bit          ok_lvl;

        kind = $urandom_range(9);
        if (kind <= 6)
        begin
            case ($urandom_range(2))
                0:       begin sel_lvl = 1'b0; ok_lvl = 1'b1; end
                1:       begin sel_lvl = 1'b1; ok_lvl = 1'b0; end
                default: begin sel_lvl = 1'b0; ok_lvl = 1'b0; end
            endcase
            repeat ($urandom_range(3))
                send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
            limit = floor_one(p_window) + p_long + 8;
            if (limit > 120)
                limit = 120;
            hold_levels(sel_lvl, ok_lvl, $urandom_range(1, limit));
            repeat ($urandom_range(2))
                send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
            hold_levels(1'b1, 1'b1,
                        $urandom_range(1, floor_one(p_window) + floor_one(p_hold) + 4));
        end
        else if (kind <= 8)
        begin
            repeat ($urandom_range(1, 8))
                send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        else
        begin
            send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
            hold_levels(1'b1, 1'b1, $urandom_range(12));
        end
    endtask

    task automatic test_random(input int n_ticks);
        int target;
        int chunk_end;

        target = ticks_sent + n_ticks;
        while (ticks_sent < target)
        begin
            settle();
            random_config();
            chunk_end = ticks_sent + 50;
            while (ticks_sent < chunk_end && ticks_sent < target)
                press_sequence();
        end
        settle();
    endtask

    initial
    begin
        int waited;

        item_ch.valid        = 1'b0;
        item_ch.select_level = 1'b1;
        item_ch.ok_level     = 1'b1;
        result_ch.ready      = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        rst_n                = 1'b0;
        src_idle_pct         = 9;
        snk_idle_pct         = 65;
        stall_cycles         = 0;
        reset_predictor();

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_defaults();
        test_press_kinds();
        test_zero_regs();
        test_extremes();
        test_backpressure();

        test_random(80);
        src_idle_pct = 65;
        snk_idle_pct = 9;
        test_random(80);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random(80);

        // let the last results come in, then look for stragglers
        item_ch.valid <= 1'b0;
        waited = 0;
        while (expected_events.size() != 0 && waited < 5000)
        begin
            @(negedge clk);
            waited++;
        end
        if (expected_events.size() != 0)
            note_failure($sformatf("%0d expected results never arrived",
                                   expected_events.size()));
        repeat (20) @(negedge clk);

        $display("Covered %0d ticks and %0d register writes over reset, zero, extreme and random settings",
                 ticks_taken, reg_writes);
        $display("Checked %0d results (%0d bounce, %0d short, %0d long), %0d failures",
                 results_seen, bounce_cnt, short_cnt, long_cnt, failures);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/tbpc_pkg.sv
sv/tbpc_if.sv
sv/tbpc_cfg.sv
sv/tbpc_core.sv
sv/tbpc_out.sv
sv/two_button_press_classifier_top.sv
verif/tb.sv
